FILE: rtl/stxfr_pkg.sv
// shared types and constants of the stx length-prefixed frame receiver
`default_nettype none

package stxfr_pkg;

  // frame layout
  localparam int unsigned IdxW = 17;
  localparam logic [7:0] StartCode = 8'h02;
  localparam logic [IdxW-1:0] FixedLen = 17'd5;
  localparam logic [IdxW-1:0] MaxLenReset = 17'd64;
  localparam logic [IdxW-1:0] IdxLenHigh = 17'd1;
  localparam logic [IdxW-1:0] IdxLenLow = 17'd2;

  // input action codes
  localparam logic ActByte = 1'b0;
  localparam logic ActTimeout = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_PROGRESS  = 3'd0,
    VERDICT_GOOD      = 3'd1,
    VERDICT_CHECK_ERR = 3'd2,
    VERDICT_TOO_LONG  = 3'd3,
    VERDICT_TIMEOUT   = 3'd4
  } verdict_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      frame_byte;
    logic [IdxW-1:0] byte_index;
    logic            frame_end;
    verdict_e        verdict;
  } result_t;

  // handshake status from the result register to the input register
  typedef struct packed {
    logic space;
  } out_status_t;

endpackage

`default_nettype wire

FILE: rtl/stxfr_in_if.sv
// input channel: received bytes and timeout events
`default_nettype none

interface stxfr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/stxfr_out_if.sv
// output channel: echoed frame bytes with index and verdict
`default_nettype none

interface stxfr_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  frame_byte;
  logic [stxfr_pkg::IdxW-1:0]  byte_index;
  logic                        frame_end;
  logic [2:0]                  verdict;

  modport source (output valid, output frame_byte, output byte_index,
                  output frame_end, output verdict, input ready);
  modport sink (input valid, input frame_byte, input byte_index,
                input frame_end, input verdict, output ready);
endinterface

`default_nettype wire

FILE: rtl/stx_length_xor_frame_receiver.sv
// top level of the stx length-prefixed frame receiver with xor check
//
// rx_i takes one item per transfer: a received byte (action 0) or a receive
// timeout event (action 1). Bytes are dropped while hunting for the start
// code; from the start code on, each frame byte is echoed on res_o with its
// index. Indices 1 and 2 carry a big-endian body length L, the frame is L + 5
// bytes, and the closing byte is checked against the xor of all bytes before
// it. The closing result has frame_end set and a verdict: good, checksum
// error, too long (flagged on the low length byte when L + 5 exceeds
// cfg_wdata_i as last written) or timeout. Timeouts always give one result.
// An item is held in the input register until the result register has room,
// and its result is then held in the result register until res_o takes it.
// One item per cycle is sustained while res_o is ready; the frame counter and
// running xor update as each item leaves the input register.
// A stalled res_o holds its result; the input register still takes one more
// item, then rx_i.ready drops until res_o moves on. Reset clears the frame
// state to hunting, empties both registers, sets max frame length to 64.
// Write it via cfg_we_i only while the block is idle; nothing enforces this.
`default_nettype none

module stx_length_xor_frame_receiver (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [stxfr_pkg::IdxW-1:0]    cfg_wdata_i,
  stxfr_in_if.sink                     rx_i,
  stxfr_out_if.source                  res_o
);

  stxfr_pkg::out_status_t out_status;
  stxfr_pkg::in_item_t    item;
  stxfr_pkg::result_t     result;
  logic                   fire;
  logic                   emit;

  // input register
  stxfr_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .out_status_i (out_status),
    .fire_o       (fire),
    .item_o       (item)
  );

  // frame tracking and verdict
  stxfr_deframer u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .emit_o      (emit),
    .result_o    (result)
  );

  // result register
  stxfr_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (fire & emit),
    .result_i     (result),
    .out_status_o (out_status),
    .res_o        (res_o)
  );

endmodule

`default_nettype wire

FILE: rtl/stxfr_in_stage.sv
// input register: holds one accepted item until the deframer takes it
`default_nettype none

module stxfr_in_stage (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  stxfr_in_if.sink                  rx_i,
  input  stxfr_pkg::out_status_t    out_status_i,
  output logic                      fire_o,
  output stxfr_pkg::in_item_t       item_o
);

  logic                valid_q, valid_d;
  stxfr_pkg::in_item_t item_q;

  // item moves on when the result register has room
  assign fire_o     = valid_q & out_status_i.space;
  assign rx_i.ready = ~valid_q | out_status_i.space;
  assign item_o     = item_q;

  // occupancy
  always_comb begin
    valid_d = valid_q;
    if (rx_i.valid && rx_i.ready) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture on each transfer
  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      item_q.action  <= rx_i.action;
      item_q.rx_byte <= rx_i.rx_byte;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/stxfr_deframer.sv
// frame state, length register, running xor and verdict logic
`default_nettype none

module stxfr_deframer (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [stxfr_pkg::IdxW-1:0]    cfg_wdata_i,
  input  wire                          fire_i,
  input  stxfr_pkg::in_item_t          item_i,
  output logic                         emit_o,
  output stxfr_pkg::result_t           result_o
);

  logic [stxfr_pkg::IdxW-1:0] max_len_q;
  logic [stxfr_pkg::IdxW-1:0] bytes_q, bytes_d;
  logic [7:0]                 len_high_q, len_high_d;
  logic [15:0]                body_len_q, body_len_d;
  logic [7:0]                 xor_q, xor_d;

  logic [15:0]                len_w;
  logic [stxfr_pkg::IdxW-1:0] total_w;
  logic [stxfr_pkg::IdxW-1:0] idx_next_w;
  logic [7:0]                 b_w;

  assign b_w        = item_i.rx_byte;
  assign len_w      = (bytes_q == stxfr_pkg::IdxLenLow) ? {len_high_q, b_w} : body_len_q;
  assign total_w    = {1'b0, len_w} + stxfr_pkg::FixedLen;
  assign idx_next_w = bytes_q + 17'd1;

  // next state and result for the item in the input register
  always_comb begin
    bytes_d    = bytes_q;
    len_high_d = len_high_q;
    body_len_d = body_len_q;
    xor_d      = xor_q;
    emit_o     = 1'b0;
    result_o.frame_byte = b_w;
    result_o.byte_index = bytes_q;
    result_o.frame_end  = 1'b0;
    result_o.verdict    = stxfr_pkg::VERDICT_PROGRESS;

    if (item_i.action == stxfr_pkg::ActTimeout) begin
      // abort, report and hunt again
      emit_o              = 1'b1;
      result_o.frame_byte = 8'h00;
      result_o.frame_end  = 1'b1;
      result_o.verdict    = stxfr_pkg::VERDICT_TIMEOUT;
      bytes_d    = '0;
      len_high_d = '0;
      body_len_d = '0;
      xor_d      = '0;
    end else if (bytes_q == '0) begin
      // hunting: only the start code opens a frame
      if (b_w == stxfr_pkg::StartCode) begin
        emit_o  = 1'b1;
        xor_d   = b_w;
        bytes_d = 17'd1;
      end
    end else begin
      emit_o = 1'b1;
      if (bytes_q == stxfr_pkg::IdxLenHigh) begin
        len_high_d = b_w;
      end
      if (bytes_q == stxfr_pkg::IdxLenLow) begin
        body_len_d = len_w;
      end

      if (bytes_q == stxfr_pkg::IdxLenLow && total_w > max_len_q) begin
        // length exceeds the configured maximum
        result_o.frame_end = 1'b1;
        result_o.verdict   = stxfr_pkg::VERDICT_TOO_LONG;
        bytes_d    = '0;
        len_high_d = '0;
        body_len_d = '0;
        xor_d      = '0;
      end else if (bytes_q >= stxfr_pkg::IdxLenLow && idx_next_w >= total_w) begin
        // closing byte carries the check
        result_o.frame_end = 1'b1;
        result_o.verdict   = (b_w == xor_q) ? stxfr_pkg::VERDICT_GOOD
                                            : stxfr_pkg::VERDICT_CHECK_ERR;
        bytes_d    = '0;
        len_high_d = '0;
        body_len_d = '0;
        xor_d      = '0;
      end else begin
        xor_d   = xor_q ^ b_w;
        bytes_d = idx_next_w;
      end
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= stxfr_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q    <= '0;
      len_high_q <= '0;
      body_len_q <= '0;
      xor_q      <= '0;
    end else if (fire_i) begin
      bytes_q    <= bytes_d;
      len_high_q <= len_high_d;
      body_len_q <= body_len_d;
      xor_q      <= xor_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/stxfr_out_stage.sv
// result register driving the output channel
`default_nettype none

module stxfr_out_stage (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       load_i,
  input  stxfr_pkg::result_t        result_i,
  output stxfr_pkg::out_status_t    out_status_o,
  stxfr_out_if.source               res_o
);

  logic               valid_q, valid_d;
  stxfr_pkg::result_t data_q;

  assign out_status_o.space = ~valid_q | res_o.ready;

  assign res_o.valid      = valid_q;
  assign res_o.frame_byte = data_q.frame_byte;
  assign res_o.byte_index = data_q.byte_index;
  assign res_o.frame_end  = data_q.frame_end;
  assign res_o.verdict    = data_q.verdict;

  // occupancy: a new result may replace one being transferred
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

`default_nettype wire
